@@ rtl/assert_macros.svh @@
// ------------------------------------------------------------------------
// assertion macros
// shared property shapes for the checker files, clocked on clk, off in rst
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GRAT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GRAT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/grat_pkg.sv @@
// ------------------------------------------------------------------------
// grat_pkg
// shared types and constants of the guest region address translator
// ------------------------------------------------------------------------
package grat_pkg;

  localparam int REGIONS_DEF   = 8;
  localparam int PAGE_BITS_DEF = 12;
  localparam int ADDR_W        = 64;
  localparam int LEN_W         = 32;
  localparam int INDEX_W       = 4;
  localparam int KIND_W        = 3;
  localparam int STATUS_W      = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_MAP       = 3'd0,
    KIND_UNMAP     = 3'd1,
    KIND_UNMAP_ALL = 3'd2,
    KIND_USER      = 3'd3,
    KIND_GUEST     = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK               = 3'd0,
    ST_BAD_INDEX        = 3'd1,
    ST_SIZE_UNALIGNED   = 3'd2,
    ST_OFFSET_UNALIGNED = 3'd3,
    ST_BUSY             = 3'd4,
    ST_NO_REGION        = 3'd5,
    ST_CROSSES          = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_REMAIN,
    SEQ_HOST,
    SEQ_DONE
  } state_t;

endpackage

@@ rtl/grat_addsub.sv @@
// ------------------------------------------------------------------------
// grat_addsub
// shared 64-bit add / subtract unit with carry out (carry set = no borrow)
// ------------------------------------------------------------------------
module grat_addsub (
  input  logic [grat_pkg::ADDR_W-1:0] a,
  input  logic [grat_pkg::ADDR_W-1:0] b,
  input  logic                        sub,
  output logic [grat_pkg::ADDR_W-1:0] sum,
  output logic                        carry
);

  logic [grat_pkg::ADDR_W-1:0] b_op;

  assign b_op = sub ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_op} + {{grat_pkg::ADDR_W{1'b0}}, sub};

endmodule

@@ rtl/guest_region_address_translator.sv @@
// map, unmap, unmap-all, undefined kinds and zero-length guest lookups go straight to the
// result beat; a user hit steps scan, host and a guest hit scan, remain, host (also past the end)
// a miss scans all REGIONS slots, one per cycle through one shared adder
// one item at a time: the next request beat can be taken in the cycle the response goes valid,
// later while an earlier response beat is still stalled
// rst (synchronous) clears all slot valid bits, the sequencer and the result beat
// ------------------------------------------------------------------------
// guest_region_address_translator
// region table with map / unmap / unmap-all and user or guest address lookup
// ------------------------------------------------------------------------
module guest_region_address_translator #(
  parameter int REGIONS   = grat_pkg::REGIONS_DEF,
  parameter int PAGE_BITS = grat_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [grat_pkg::KIND_W-1:0]   kind,
  input  logic [grat_pkg::INDEX_W-1:0]  region_index,
  input  logic [grat_pkg::ADDR_W-1:0]   guest_base,
  input  logic [grat_pkg::ADDR_W-1:0]   user_base,
  input  logic [grat_pkg::ADDR_W-1:0]   host_base,
  input  logic [grat_pkg::ADDR_W-1:0]   region_bytes,
  input  logic [grat_pkg::ADDR_W-1:0]   map_offset,
  input  logic [grat_pkg::ADDR_W-1:0]   lookup_addr,
  input  logic [grat_pkg::LEN_W-1:0]    lookup_len,
  // response channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [grat_pkg::STATUS_W-1:0] status,
  output logic [grat_pkg::ADDR_W-1:0]   host_addr
);

  localparam int IDX_W    = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int IDXCHK_W = grat_pkg::INDEX_W + 1;
  localparam int PAGES_W  = grat_pkg::ADDR_W - PAGE_BITS;

  // region table: valid bits reset, payload only meaningful while valid
  logic                        slot_valid      [REGIONS];
  logic [grat_pkg::ADDR_W-1:0] slot_guest_base [REGIONS];
  logic [grat_pkg::ADDR_W-1:0] slot_user_base  [REGIONS];
  logic [grat_pkg::ADDR_W-1:0] slot_host_base  [REGIONS];
  logic [PAGES_W-1:0]          slot_pages      [REGIONS];

  // sequencer
  grat_pkg::state_t state, state_next;

  // item context held over the scan
  logic                        is_guest;
  logic [grat_pkg::ADDR_W-1:0] addr_q;
  logic [grat_pkg::LEN_W-1:0]  len_m1;
  logic [IDX_W-1:0]            scan_idx;
  logic [grat_pkg::ADDR_W-1:0] off;
  logic [grat_pkg::ADDR_W-1:0] rem;
  grat_pkg::status_t           res_status;
  logic [grat_pkg::ADDR_W-1:0] res_host;

  // response beat register
  logic [grat_pkg::STATUS_W-1:0] status_q;
  logic [grat_pkg::ADDR_W-1:0]   host_q;

  // shared adder
  logic [grat_pkg::ADDR_W-1:0] alu_a, alu_b, alu_sum;
  logic                        alu_sub, alu_carry;

  logic                        accept;
  logic                        out_free;
  logic                        idx_ok;
  logic [IDX_W-1:0]            map_idx;
  logic                        size_bad, offs_bad;
  grat_pkg::status_t           map_status;
  logic                        map_wr;
  logic [grat_pkg::ADDR_W-1:0] scan_base;
  logic [grat_pkg::ADDR_W-1:0] sel_bytes;
  logic                        scan_hit;
  logic                        scan_last;
  logic                        crosses;

  assign req_stall = (state != grat_pkg::SEQ_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // map / unmap checks straight off the request beat
  assign idx_ok   = ({1'b0, region_index} < IDXCHK_W'(REGIONS));
  assign map_idx  = region_index[IDX_W-1:0];
  assign size_bad = (region_bytes[PAGE_BITS-1:0] != '0);
  assign offs_bad = (map_offset[PAGE_BITS-1:0] != '0);

  always_comb begin
    if (!idx_ok) begin
      map_status = grat_pkg::ST_BAD_INDEX;
    end else if (size_bad) begin
      map_status = grat_pkg::ST_SIZE_UNALIGNED;
    end else if (offs_bad) begin
      map_status = grat_pkg::ST_OFFSET_UNALIGNED;
    end else if (slot_valid[map_idx]) begin
      map_status = grat_pkg::ST_BUSY;
    end else begin
      map_status = grat_pkg::ST_OK;
    end
  end

  assign map_wr = accept && (kind == grat_pkg::KIND_MAP) && (map_status == grat_pkg::ST_OK);

  // slot under the scan pointer
  assign scan_base = is_guest ? slot_guest_base[scan_idx] : slot_user_base[scan_idx];
  assign sel_bytes = {slot_pages[scan_idx], {PAGE_BITS{1'b0}}};
  assign scan_last = (scan_idx == IDX_W'(REGIONS - 1));

  // start inside the slot: no borrow on addr - base, and offset below the size
  assign scan_hit = slot_valid[scan_idx] && alu_carry && (alu_sum < sel_bytes);

  // guest range runs past the end when len - 1 >= bytes - off
  assign crosses = ({{(grat_pkg::ADDR_W - grat_pkg::LEN_W){1'b0}}, len_m1} >= rem);

  // operand steering for the one adder
  always_comb begin
    case (state)
      grat_pkg::SEQ_SCAN: begin
        alu_a   = addr_q;
        alu_b   = scan_base;
        alu_sub = 1'b1;
      end
      grat_pkg::SEQ_REMAIN: begin
        alu_a   = sel_bytes;
        alu_b   = off;
        alu_sub = 1'b1;
      end
      grat_pkg::SEQ_HOST: begin
        alu_a   = slot_host_base[scan_idx];
        alu_b   = off;
        alu_sub = 1'b0;
      end
      default: begin
        alu_a   = addr_q;
        alu_b   = off;
        alu_sub = 1'b0;
      end
    endcase
  end

  grat_addsub u_addsub (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      grat_pkg::SEQ_IDLE: begin
        if (req_valid) begin
          case (kind)
            grat_pkg::KIND_USER:  state_next = grat_pkg::SEQ_SCAN;
            grat_pkg::KIND_GUEST: begin
              // zero-length range misses without a scan
              state_next = (lookup_len == '0) ? grat_pkg::SEQ_DONE : grat_pkg::SEQ_SCAN;
            end
            default:              state_next = grat_pkg::SEQ_DONE;
          endcase
        end
      end
      grat_pkg::SEQ_SCAN: begin
        if (scan_hit) begin
          state_next = is_guest ? grat_pkg::SEQ_REMAIN : grat_pkg::SEQ_HOST;
        end else if (scan_last) begin
          state_next = grat_pkg::SEQ_DONE;
        end
      end
      grat_pkg::SEQ_REMAIN: state_next = grat_pkg::SEQ_HOST;
      grat_pkg::SEQ_HOST:   state_next = grat_pkg::SEQ_DONE;
      grat_pkg::SEQ_DONE: begin
        if (out_free) begin
          state_next = grat_pkg::SEQ_IDLE;
        end
      end
      default: state_next = grat_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grat_pkg::SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // valid bits: map sets, unmap clears one, unmap-all clears every slot
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REGIONS; i++) begin
        slot_valid[i] <= 1'b0;
      end
    end else if (accept) begin
      if (map_wr) begin
        slot_valid[map_idx] <= 1'b1;
      end else if ((kind == grat_pkg::KIND_UNMAP) && idx_ok) begin
        slot_valid[map_idx] <= 1'b0;
      end else if (kind == grat_pkg::KIND_UNMAP_ALL) begin
        for (int i = 0; i < REGIONS; i++) begin
          slot_valid[i] <= 1'b0;
        end
      end
    end
  end

  // slot payload, written on a successful map
  always_ff @(posedge clk) begin
    if (map_wr) begin
      slot_guest_base[map_idx] <= guest_base;
      slot_user_base[map_idx]  <= user_base;
      slot_host_base[map_idx]  <= host_base;
      slot_pages[map_idx]      <= region_bytes[grat_pkg::ADDR_W-1:PAGE_BITS];
    end
  end

  // item context and result build-up
  always_ff @(posedge clk) begin
    case (state)
      grat_pkg::SEQ_IDLE: begin
        if (accept) begin
          is_guest <= (kind == grat_pkg::KIND_GUEST);
          addr_q   <= lookup_addr;
          len_m1   <= lookup_len - 1'b1;
          scan_idx <= '0;
          res_host <= '0;
          case (kind)
            grat_pkg::KIND_MAP:       res_status <= map_status;
            grat_pkg::KIND_UNMAP: begin
              res_status <= idx_ok ? grat_pkg::ST_OK : grat_pkg::ST_BAD_INDEX;
            end
            grat_pkg::KIND_UNMAP_ALL: res_status <= grat_pkg::ST_OK;
            // lookups and undefined kinds start as a miss
            default:                  res_status <= grat_pkg::ST_NO_REGION;
          endcase
        end
      end
      grat_pkg::SEQ_SCAN: begin
        if (scan_hit) begin
          off <= alu_sum;
        end else if (!scan_last) begin
          scan_idx <= IDX_W'(scan_idx + 1'b1);
        end
      end
      grat_pkg::SEQ_REMAIN: begin
        rem <= alu_sum;
      end
      grat_pkg::SEQ_HOST: begin
        if (is_guest && crosses) begin
          res_status <= grat_pkg::ST_CROSSES;
        end else begin
          res_status <= grat_pkg::ST_OK;
          res_host   <= alu_sum;
        end
      end
      default: begin
      end
    endcase
  end

  // response beat: loads when the register is empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == grat_pkg::SEQ_DONE) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == grat_pkg::SEQ_DONE) && out_free) begin
      status_q <= res_status;
      host_q   <= res_host;
    end
  end

  assign status    = status_q;
  assign host_addr = host_q;

endmodule

@@ rtl/grat_checker.sv @@
// ------------------------------------------------------------------------
// grat_checker
// port-level checks on the address translator, bound to the top level
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module grat_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_stall,
  input logic                          rsp_valid,
  input logic                          rsp_stall,
  input logic [grat_pkg::STATUS_W-1:0] status,
  input logic [grat_pkg::ADDR_W-1:0]   host_addr
);

  // only defined status codes leave the block
  `GRAT_ASSERT_IMP(a_status_range, rsp_valid, status <= grat_pkg::ST_CROSSES, "undefined status")

  // a failed item never carries a host address
  `GRAT_ASSERT_IMP(a_fail_zero, rsp_valid && (status != grat_pkg::ST_OK), host_addr == '0, "host address on failure")

  // one item at a time: busy right after a request beat
  `GRAT_ASSERT_NXT(a_busy_after_beat, req_valid && !req_stall, req_stall, "second beat taken while busy")

  // stalled response beat holds
  `GRAT_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(host_addr), "stalled response changed")

endmodule

bind guest_region_address_translator grat_checker u_grat_checker (.*);
